>>> hdl/sssp_pkg.sv
`timescale 1ns / 1ps
package sssp_pkg;
  localparam int NODES = 256;
  localparam int EDGES = 4096;
  localparam int NODE_W = $clog2(NODES);
  localparam int EDGE_W = $clog2(EDGES);
  localparam int CNT_W = $clog2(EDGES + 1);
  localparam int TOT_W = $clog2(NODES + 1);
  localparam int DIST_W = 24;
  localparam logic [DIST_W-1:0] UNREACHED_DIST = 24'd1000000;
  localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
  localparam int EDGE_REC_W = 32;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;
  localparam logic [1:0] CMD_RUN = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  from_node;
    logic [7:0]  to_node;
    logic [15:0] edge_weight;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [23:0] distance;
    logic        reached;
    logic [8:0]  settled_count;
  } out_word_t;
endpackage

>>> hdl/sssp_ram.sv
`timescale 1ns / 1ps
module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/single_source_shortest_paths_top.sv
`timescale 1ns / 1ps
// Single-source shortest paths (naive Dijkstra) over a stored edge table.
// Commands enter on start/cmd while busy is low; each command yields exactly
// one word on result, marked by result_valid for one cycle. The receiver
// cannot stall, so a result is never held back.
// Clear sweeps the per-vertex distance memory.
// Add edge goes straight to done; read distance passes READ0 and READ1.
// Run first sweeps the vertex memory, then does up to NODES-1
// rounds; each round streams the edge table through the one read port of
// the edge memory and the two copies of the distance memory, one edge a
// cycle, then drains the pipeline and settles the nearest vertex.
// The source vertex is written over the APB port at address 0; the user must
// write it only while idle, which the block does not enforce. After reset
// the block sweeps the vertex memory (busy high); the edge table itself is
// never cleared and is read only below its count.
module single_source_shortest_paths_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sssp_pkg::in_word_t   cmd,
  output logic                 result_valid,
  output sssp_pkg::out_word_t  result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_SEED, S_SCAN, S_DRAIN, S_SETTLE, S_READ0, S_READ1, S_DONE
  } state_t;

  state_t state;
  logic [7:0] source_node;
  logic [sssp_pkg::CNT_W-1:0] edge_count;
  logic [sssp_pkg::TOT_W-1:0] settled_total;
  logic [sssp_pkg::NODE_W:0] wipe_idx;
  logic [sssp_pkg::CNT_W-1:0] scan_idx;
  logic [sssp_pkg::TOT_W-1:0] round;
  logic [1:0] cmd_op;
  logic [7:0] cmd_to;
  logic found;
  logic [23:0] min_dist;
  logic [sssp_pkg::NODE_W-1:0] pick;
  logic status_r;

  // Edge table memory.
  logic e_we;
  logic [sssp_pkg::EDGE_W-1:0] e_raddr;
  logic [sssp_pkg::EDGE_REC_W-1:0] e_wdata, e_rdata;
  // Vertex memory: settled flag and distance.
  logic v_we;
  logic [sssp_pkg::NODE_W-1:0] v_waddr, v_raddr, vb_raddr;
  logic [24:0] v_wdata, va_rdata, vb_rdata;

  assign pready = 1'b1;
  assign prdata = {24'd0, source_node};
  assign busy = (state != S_IDLE);

  sssp_ram #(.WIDTH(sssp_pkg::EDGE_REC_W), .DEPTH(sssp_pkg::EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(edge_count[sssp_pkg::EDGE_W-1:0]),
    .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  // Two copies of the vertex memory give a read for each end of an edge.
  sssp_ram #(.WIDTH(25), .DEPTH(sssp_pkg::NODES)) u_vert_a (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(va_rdata)
  );
  sssp_ram #(.WIDTH(25), .DEPTH(sssp_pkg::NODES)) u_vert_b (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(vb_raddr), .rdata(vb_rdata)
  );

  // Stage 1: edge word read; stage 2: its two vertices read.
  logic p1_valid, p2_valid;
  logic [15:0] p2_len;
  logic [7:0] p2_a, p2_b;
  logic [7:0] ea, eb;
  assign ea = e_rdata[31:24];
  assign eb = e_rdata[23:16];
  assign e_raddr = scan_idx[sssp_pkg::EDGE_W-1:0];
  assign v_raddr = (state inside {S_READ0, S_READ1}) ? cmd_to[sssp_pkg::NODE_W-1:0]
                                                     : ea[sssp_pkg::NODE_W-1:0];
  assign vb_raddr = eb[sssp_pkg::NODE_W-1:0];

  logic [24:0] cand_sum;
  logic [23:0] cand;
  logic qual;
  assign cand_sum = {1'b0, va_rdata[23:0]} + {9'd0, p2_len};
  assign cand = cand_sum[24] ? sssp_pkg::DIST_MAX : cand_sum[23:0];
  assign qual = p2_valid && (p2_a < sssp_pkg::NODES) && (p2_b < sssp_pkg::NODES)
                && va_rdata[24] && !vb_rdata[24];

  // Memory writes.
  always_comb begin
    e_we = (state == S_IDLE) && start && (cmd.command == sssp_pkg::CMD_ADD)
           && (edge_count < sssp_pkg::EDGES);
    e_wdata = {cmd.from_node, cmd.to_node, cmd.edge_weight};
    v_we = 1'b0;
    v_waddr = wipe_idx[sssp_pkg::NODE_W-1:0];
    v_wdata = '0;
    case (state)
      S_WIPE: v_we = 1'b1;
      S_SEED: begin
        v_we = (source_node < sssp_pkg::NODES);
        v_waddr = source_node[sssp_pkg::NODE_W-1:0];
        v_wdata = {1'b1, 24'd0};
      end
      S_SETTLE: begin
        v_we = found;
        v_waddr = pick;
        v_wdata = {1'b1, min_dist};
      end
      default: ;
    endcase
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      source_node <= '0;
      edge_count <= '0;
      settled_total <= '0;
      wipe_idx <= '0;
      result_valid <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      // The reset sweep ends in idle without a result word.
      cmd_op <= sssp_pkg::CMD_ADD;
    end else begin
      result_valid <= 1'b0;
      if (psel && penable && pwrite && !paddr) begin
        source_node <= pwdata[7:0];
      end
      p2_valid <= p1_valid;
      p2_a <= ea;
      p2_b <= eb;
      p2_len <= e_rdata[15:0];
      case (state)
        S_WIPE: begin
          wipe_idx <= wipe_idx + 1'b1;
          if (wipe_idx == (sssp_pkg::NODES - 1)) begin
            wipe_idx <= '0;
            settled_total <= '0;
            state <= (cmd_op == sssp_pkg::CMD_RUN) ? S_SEED :
                     (cmd_op == sssp_pkg::CMD_CLEAR) ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_op <= cmd.command;
            cmd_to <= cmd.to_node;
            status_r <= 1'b0;
            case (cmd.command)
              sssp_pkg::CMD_CLEAR: begin
                edge_count <= '0;
                state <= S_WIPE;
              end
              sssp_pkg::CMD_ADD: begin
                if (edge_count < sssp_pkg::EDGES) edge_count <= edge_count + 1'b1;
                else status_r <= 1'b1;
                state <= S_DONE;
              end
              sssp_pkg::CMD_RUN: state <= S_WIPE;
              default: state <= S_READ0;
            endcase
          end
        end
        S_SEED: begin
          settled_total <= {{(sssp_pkg::TOT_W-1){1'b0}}, (source_node < sssp_pkg::NODES)};
          round <= {{(sssp_pkg::TOT_W-1){1'b0}}, 1'b1};
          scan_idx <= '0;
          found <= 1'b0;
          if (source_node < sssp_pkg::NODES && round != 0) state <= S_SCAN;
          else if (source_node < sssp_pkg::NODES) state <= S_SCAN;
          else state <= S_DONE;
          p1_valid <= 1'b0;
        end
        S_SCAN: begin
          // The edge read issued this cycle is valid only below the count.
          p1_valid <= (scan_idx < edge_count);
          if (scan_idx + 1'b1 < edge_count) begin
            scan_idx <= scan_idx + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          p1_valid <= 1'b0;
          if (!p1_valid && !p2_valid) state <= S_SETTLE;
        end
        S_SETTLE: begin
          if (found && round < (sssp_pkg::NODES - 1)) begin
            settled_total <= settled_total + 1'b1;
            round <= round + 1'b1;
            scan_idx <= '0;
            found <= 1'b0;
            p1_valid <= 1'b0;
            state <= S_SCAN;
          end else begin
            if (found) settled_total <= settled_total + 1'b1;
            state <= S_DONE;
          end
        end
        S_READ0: state <= S_READ1;
        S_READ1: state <= S_DONE;
        S_DONE: begin
          result_valid <= 1'b1;
          result.status <= status_r;
          result.distance <= '0;
          result.reached <= 1'b0;
          result.settled_count <= settled_total;
          if (cmd_op == sssp_pkg::CMD_READ) begin
            if (cmd_to < sssp_pkg::NODES && va_rdata[24]) begin
              result.distance <= va_rdata[23:0];
              result.reached <= 1'b1;
            end else begin
              result.distance <= sssp_pkg::UNREACHED_DIST;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // Track the strictly smallest candidate in table order.
      if (qual && (!found || cand < min_dist)) begin
        found <= 1'b1;
        min_dist <= cand;
        pick <= p2_b[sssp_pkg::NODE_W-1:0];
      end
    end
  end

  // A result word is only given from the completion state.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == S_DONE)
    else $error("result without completion");
  // The block is busy while a word is being produced.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> busy)
    else $error("idle during completion");
  // The edge count never passes the table size.
  assert property (@(posedge clk) disable iff (rst)
    edge_count <= sssp_pkg::EDGES)
    else $error("edge count overflow");
  // Settled vertices never exceed the vertex count.
  assert property (@(posedge clk) disable iff (rst)
    settled_total <= sssp_pkg::NODES)
    else $error("settled total overflow");
endmodule
